// ----- hdl/ubxsd_pkg.sv -----
// shared types and constants for the framed servo command receiver
// no dependencies
package ubxsd_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int SERVO_COUNT = 6;
    localparam int SERVO_BYTES = 12;
    localparam int BIDX_W      = $clog2(SERVO_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 3;

    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [7:0]  ID_START    = 8'h11;
    localparam logic [7:0]  ID_SERVO    = 8'h13;
    localparam logic [7:0]  CLASS_RESET = 8'h10;
    localparam logic [15:0] LIMIT_RESET = 16'd2000;

    localparam logic REG_CLASS = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        KIND_SERVO   = 3'd0,
        KIND_START   = 3'd1,
        KIND_CKERR   = 3'd2,
        KIND_REJECT  = 3'd3,
        KIND_TOOLONG = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               count;
        logic [SERVO_BYTES*8-1:0] bytes;
    } job_t;

endpackage

// ----- hdl/ubxsd_front.sv -----
// byte parser: sync hunt, header, payload capture and checksum
// emits one job per finished frame or error; uses ubxsd_pkg
module ubxsd_front #(
    parameter int MAX_PAYLOAD = ubxsd_pkg::MAX_PAYLOAD
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        accepted_class,
    input  logic              q_full,
    output logic              job_valid,
    output ubxsd_pkg::job_t   job
);

    typedef enum logic [9:0] {
        PH_HUNT1     = 10'b0000000001,
        PH_HUNT2     = 10'b0000000010,
        PH_CLASS     = 10'b0000000100,
        PH_ID        = 10'b0000001000,
        PH_LEN_LO    = 10'b0000010000,
        PH_LEN_HI    = 10'b0000100000,
        PH_PAYLOAD   = 10'b0001000000,
        PH_CK_A      = 10'b0010000000,
        PH_CK_B_GOOD = 10'b0100000000,
        PH_CK_B_BAD  = 10'b1000000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  handled_reg, handled_next;
    logic [7:0]  bytes_reg [ubxsd_pkg::SERVO_BYTES];
    logic [7:0]  bytes_next [ubxsd_pkg::SERVO_BYTES];

    logic        take;
    logic        emit;
    logic [7:0]  sa_add, sb_add;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    ubxsd_pkg::kind_t kind;

    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;
    assign sa_add    = sum_a_reg + rx_byte;
    assign sb_add    = sum_b_reg + sa_add;
    assign len_full  = {rx_byte, length_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        class_next   = class_reg;
        id_next      = id_reg;
        handled_next = handled_reg;
        bytes_next   = bytes_reg;
        emit         = 1'b0;
        kind         = ubxsd_pkg::KIND_REJECT;
        case (phase_reg)
            PH_HUNT1: begin
                if (rx_byte == ubxsd_pkg::SYNC_FIRST) phase_next = PH_HUNT2;
            end
            PH_HUNT2: begin
                if (rx_byte == ubxsd_pkg::SYNC_SECOND) begin
                    phase_next  = PH_CLASS;
                    sum_a_next  = 8'd0;
                    sum_b_next  = 8'd0;
                    count_next  = 16'd0;
                    length_next = 16'd0;
                    for (int i = 0; i < ubxsd_pkg::SERVO_BYTES; i++) bytes_next[i] = 8'd0;
                end else if (rx_byte != ubxsd_pkg::SYNC_FIRST) begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                class_next = rx_byte;
                sum_a_next = sa_add;
                sum_b_next = sb_add;
                phase_next = PH_ID;
            end
            PH_ID: begin
                id_next    = rx_byte;
                sum_a_next = sa_add;
                sum_b_next = sb_add;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {8'd0, rx_byte};
                sum_a_next  = sa_add;
                sum_b_next  = sb_add;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = len_full;
                sum_a_next  = sa_add;
                sum_b_next  = sb_add;
                if (len_full > 16'(MAX_PAYLOAD)) begin
                    emit       = 1'b1;
                    kind       = ubxsd_pkg::KIND_TOOLONG;
                    phase_next = PH_HUNT1;
                end else if (len_full == 16'd0) begin
                    phase_next = PH_CK_A;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (count_reg < 16'(ubxsd_pkg::SERVO_BYTES))
                    bytes_next[count_reg[ubxsd_pkg::BIDX_W-1:0]] = rx_byte;
                sum_a_next = sa_add;
                sum_b_next = sb_add;
                count_next = count_inc;
                if (count_inc >= length_reg) phase_next = PH_CK_A;
            end
            PH_CK_A: begin
                phase_next = (rx_byte == sum_a_reg) ? PH_CK_B_GOOD : PH_CK_B_BAD;
            end
            PH_CK_B_GOOD, PH_CK_B_BAD: begin
                emit       = 1'b1;
                phase_next = PH_HUNT1;
                if (phase_reg == PH_CK_B_BAD || rx_byte != sum_b_reg) begin
                    kind = ubxsd_pkg::KIND_CKERR;
                end else if (class_reg != accepted_class) begin
                    kind = ubxsd_pkg::KIND_REJECT;
                end else if (id_reg == ubxsd_pkg::ID_START) begin
                    kind         = ubxsd_pkg::KIND_START;
                    handled_next = handled_reg + 8'd1;
                end else if (id_reg == ubxsd_pkg::ID_SERVO) begin
                    kind         = ubxsd_pkg::KIND_SERVO;
                    handled_next = handled_reg + 8'd1;
                end else begin
                    kind = ubxsd_pkg::KIND_REJECT;
                end
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    always_comb begin
        job_valid = take && emit;
        job.kind  = kind;
        job.count = handled_next;
        for (int i = 0; i < ubxsd_pkg::SERVO_BYTES; i++) job.bytes[8*i +: 8] = bytes_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT1;
            handled_reg <= 8'd0;
        end else if (take) begin
            phase_reg   <= phase_next;
            handled_reg <= handled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            bytes_reg  <= bytes_next;
        end
    end

endmodule

// ----- hdl/ubxsd_queue.sv -----
// short job queue between the parser and the result dispatcher
// uses ubxsd_pkg
module ubxsd_queue #(
    parameter int DEPTH = ubxsd_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ubxsd_pkg::job_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ubxsd_pkg::job_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ubxsd_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  fill_reg;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop) fill_reg <= fill_reg + CNT_W'(1);
            else if (pop && !push) fill_reg <= fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/ubxsd_back.sv -----
// result dispatcher: expands queued jobs into result items with clamping
// output register on the result channel; uses ubxsd_pkg
module ubxsd_back #(
    parameter int SERVO_COUNT = ubxsd_pkg::SERVO_COUNT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  ubxsd_pkg::job_t head_data,
    output logic            pop,
    input  logic [15:0]     position_limit,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_result_kind,
    output logic [2:0]      m_servo_index,
    output logic [15:0]     m_pulse_width,
    output logic [7:0]      m_commands_done,
    output logic            m_last_of_run
);

    logic        valid_reg;
    logic [2:0]  idx_reg;
    logic [2:0]  kind_reg;
    logic [2:0]  index_reg;
    logic [15:0] pos_reg;
    logic [7:0]  done_reg;
    logic        last_reg;

    logic        is_servo;
    logic        last;
    logic        load;
    logic [15:0] word;
    logic [15:0] clamped;

    assign is_servo = (head_data.kind == ubxsd_pkg::KIND_SERVO);
    assign last     = !is_servo || (idx_reg == 3'(SERVO_COUNT - 1));
    assign load     = head_valid && (!valid_reg || m_ready);
    assign pop      = load && last;
    assign word     = head_data.bytes[{idx_reg, 4'b0000} +: 16];
    assign clamped  = (word > position_limit) ? position_limit : word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            if (load) valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
            if (load) idx_reg <= last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= head_data.kind;
            index_reg <= is_servo ? idx_reg : 3'd0;
            pos_reg   <= is_servo ? clamped : 16'd0;
            done_reg  <= head_data.count;
            last_reg  <= last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_servo_index   = index_reg;
    assign m_pulse_width   = pos_reg;
    assign m_commands_done = done_reg;
    assign m_last_of_run   = last_reg;

endmodule

// ----- hdl/ubx_frame_receiver_servo_dispatch.sv -----
// Framed servo command receiver. One received byte is taken per clock cycle;
// the parser stalls the byte stream only when the two-entry job queue is full.
// A servo set frame yields SERVO_COUNT result items, drained one per cycle by
// the dispatcher while m_ready is high; every other outcome yields one item.
// Result items pass from the queue head through the dispatcher's output
// register. Registers: 0x0 accepted class (reset 0x10), 0x4 position limit
// (reset 2000), written over the APB port.
module ubx_frame_receiver_servo_dispatch #(
    parameter int MAX_PAYLOAD = ubxsd_pkg::MAX_PAYLOAD,
    parameter int SERVO_COUNT = ubxsd_pkg::SERVO_COUNT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_result_kind,
    output logic [2:0]                   m_servo_index,
    output logic [15:0]                  m_pulse_width,
    output logic [7:0]                   m_commands_done,
    output logic                         m_last_of_run,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ubxsd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0]      class_reg;
    logic [15:0]     limit_reg;
    logic            cfg_wr;

    logic            q_push, q_full, q_pop, q_head_valid;
    ubxsd_pkg::job_t q_push_data, q_head_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg <= ubxsd_pkg::CLASS_RESET;
            limit_reg <= ubxsd_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                ubxsd_pkg::REG_CLASS: class_reg <= pwdata[7:0];
                ubxsd_pkg::REG_LIMIT: limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ubxsd_pkg::REG_CLASS: prdata = {24'd0, class_reg};
            ubxsd_pkg::REG_LIMIT: prdata = {16'd0, limit_reg};
            default:              prdata = 32'd0;
        endcase
    end

    ubxsd_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .rx_byte       (s_rx_byte),
        .accepted_class(class_reg),
        .q_full        (q_full),
        .job_valid     (q_push),
        .job           (q_push_data)
    );

    ubxsd_queue #(
        .DEPTH(ubxsd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head_data (q_head_data)
    );

    ubxsd_back #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (q_head_valid),
        .head_data      (q_head_data),
        .pop            (q_pop),
        .position_limit (limit_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_servo_index  (m_servo_index),
        .m_pulse_width  (m_pulse_width),
        .m_commands_done(m_commands_done),
        .m_last_of_run  (m_last_of_run)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full && !q_pop))
        else $error("job queue overflow");

    a_servo_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == ubxsd_pkg::KIND_SERVO)
            |-> (m_servo_index < 3'(SERVO_COUNT)))
        else $error("servo index out of range");

    a_plain_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != ubxsd_pkg::KIND_SERVO)
            |-> (m_servo_index == 3'd0 && m_pulse_width == 16'd0 && m_last_of_run))
        else $error("non-servo item malformed");

endmodule
